@@ hdl/multichannel_moving_average_macros.svh @@
// Assertion macros shared by the moving average filter.
`ifndef MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define MMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mma_pkg.sv @@
// Types, constants and the reciprocal table of the moving average filter.
package mma_pkg;

  localparam int CHAN_W      = 3;
  localparam int CHAN_XW     = 5;
  localparam int SAMPLE_W    = 12;
  localparam int SUM_W       = 16;
  localparam int POS_W       = 4;
  localparam int CNT_W       = 5;
  localparam int RECIP_W     = 22;
  localparam int RECIP_SHIFT = 21;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam int DEF_WINDOW   = 10;
  localparam int DEF_CHANNELS = 8;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] pos;
    logic             full;
  } mma_chan_st_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [SUM_W-1:0]   sum;
    logic [RECIP_W-1:0] recip;
    logic               full;
  } mma_div_req_t;

  // ceil(2^21 / d). For every 16-bit numerator and d up to 16 the product
  // shifted right by 21 is exactly the floor quotient. A count of zero maps
  // to zero so that the mean comes out as zero.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      5'd1:    m = 22'd2097152;
      5'd2:    m = 22'd1048576;
      5'd3:    m = 22'd699051;
      5'd4:    m = 22'd524288;
      5'd5:    m = 22'd419431;
      5'd6:    m = 22'd349526;
      5'd7:    m = 22'd299594;
      5'd8:    m = 22'd262144;
      5'd9:    m = 22'd233017;
      5'd10:   m = 22'd209716;
      5'd11:   m = 22'd190651;
      5'd12:   m = 22'd174763;
      5'd13:   m = 22'd161320;
      5'd14:   m = 22'd149797;
      5'd15:   m = 22'd139811;
      5'd16:   m = 22'd131072;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ hdl/mma_if.sv @@
// Valid/ready channel interfaces for sample words and result words.
interface mma_in_if;
  import mma_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   chan;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output chan, output sample, input ready);
  modport sink   (input valid, input chan, input sample, output ready);
endinterface

interface mma_out_if;
  import mma_pkg::*;

  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   chan_out;
  logic [SAMPLE_W-1:0] mean;
  logic                window_full;

  modport source (output valid, output chan_out, output mean, output window_full,
                  input ready);
  modport sink   (input valid, input chan_out, input mean, input window_full,
                  output ready);
endinterface

@@ hdl/mma_ring_mem.sv @@
// Sample ring memory for all channels, one write and one registered read port.
module mma_ring_mem #(
  parameter int DEPTH = mma_pkg::DEF_WINDOW * mma_pkg::DEF_CHANNELS,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [mma_pkg::SAMPLE_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [mma_pkg::SAMPLE_W-1:0]  wr_data
);
  import mma_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/mma_chan_state.sv @@
// Per-channel sum, write position and full flag, held in a small memory.
module mma_chan_state #(
  parameter int CHANNELS = mma_pkg::DEF_CHANNELS,
  parameter int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [CW-1:0]         rd_idx,
  output mma_pkg::mma_chan_st_t rd_data,
  input  logic                  wr_en,
  input  logic [CW-1:0]         wr_idx,
  input  mma_pkg::mma_chan_st_t wr_data
);
  import mma_pkg::*;

  mma_chan_st_t  mem [CHANNELS];
  mma_chan_st_t  rd_data_r;
  logic [CHANNELS-1:0] valid_r;
  logic          rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // A channel never written since reset reads as the all-zero state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

@@ hdl/mma_mean_div.sv @@
// Mean by reciprocal multiplication, with an operand stage and an output register.
module mma_mean_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  mma_pkg::mma_div_req_t req,
  output logic                  ready,
  mma_out_if.source             out_ch
);
  import mma_pkg::*;

  mma_div_req_t        op_r;
  logic                op_valid_r;
  logic                op_valid_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [CHAN_W-1:0]   chan_out_r;
  logic [SAMPLE_W-1:0] mean_r;
  logic                full_out_r;
  logic                out_free;
  logic                op_take;
  logic [PROD_W-1:0]   prod;

  assign out_free = !out_valid_r || out_ch.ready;
  assign op_take  = op_valid_r && out_free;
  assign ready    = !op_valid_r || out_free;
  assign prod     = PROD_W'(op_r.sum) * PROD_W'(op_r.recip);

  always_comb begin
    op_valid_nxt = op_valid_r;
    if (op_take) begin
      op_valid_nxt = 1'b0;
    end
    if (start) begin
      op_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (op_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      op_valid_r  <= op_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= req;
    end
    if (op_take) begin
      chan_out_r <= op_r.chan;
      mean_r     <= prod[RECIP_SHIFT +: SAMPLE_W];
      full_out_r <= op_r.full;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chan_out    = chan_out_r;
  assign out_ch.mean        = mean_r;
  assign out_ch.window_full = full_out_r;

endmodule

@@ hdl/multichannel_moving_average.sv @@
// Multichannel boxcar filter: one result word per sample word.
// Each word passes the channel state read, the sample ring read, the divider
// operand stage and output register. A new word is taken only after the last
// has left the dependent channel state and ring reads and entered the divider.
// Reset clears control and marks every channel empty at once; ring contents are
// undefined until written and need no clearing pass.
`include "multichannel_moving_average_macros.svh"

module multichannel_moving_average #(
  parameter int WINDOW   = mma_pkg::DEF_WINDOW,
  parameter int CHANNELS = mma_pkg::DEF_CHANNELS
) (
  input  logic       clk,
  input  logic       rst_n,
  mma_in_if.sink     in_ch,
  mma_out_if.source  out_ch
);
  import mma_pkg::*;

  localparam int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RING_DEPTH = CHANNELS * WINDOW;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD1  = 2'd1;
  localparam logic [1:0] S_RD2  = 2'd2;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  logic [CHAN_W-1:0]   chan_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                in_range_r;
  logic [RING_AW-1:0]  ring_addr_r;

  logic                in_acc;
  logic [CHAN_XW-1:0]  in_chan_x;
  logic [CHAN_XW-1:0]  chan_x_r;
  logic [CW-1:0]       chan_idx_r;
  logic [RING_AW-1:0]  ring_addr;

  mma_chan_st_t        cs_rd;
  mma_chan_st_t        cs_new;
  logic [SAMPLE_W-1:0] ring_rd;
  logic [SUM_W-1:0]    evict;
  logic [POS_W-1:0]    pos_new;
  logic [CNT_W-1:0]    count;
  mma_div_req_t        div_req;
  logic                div_ready;
  logic                div_start;
  logic                out_oor;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_chan_x  = CHAN_XW'(in_ch.chan);
  assign chan_x_r   = CHAN_XW'(chan_r);
  assign chan_idx_r = chan_x_r[CW-1:0];
  assign ring_addr  = RING_AW'(RING_AW'(chan_idx_r) * RING_AW'(WINDOW))
                    + RING_AW'(cs_rd.pos);

  // Update of the channel: evict the oldest sample only once the window is full.
  always_comb begin
    evict   = cs_rd.full ? SUM_W'(ring_rd) : '0;
    pos_new = (cs_rd.pos == POS_W'(WINDOW - 1)) ? '0 : cs_rd.pos + 1'b1;
    cs_new.sum  = cs_rd.sum - evict + SUM_W'(sample_r);
    cs_new.pos  = pos_new;
    cs_new.full = cs_rd.full || (pos_new == '0);
    count = cs_new.full ? CNT_W'(WINDOW) : CNT_W'(pos_new);
    div_req.chan = chan_r;
    if (in_range_r) begin
      div_req.sum   = cs_new.sum;
      div_req.recip = recip(count);
      div_req.full  = cs_new.full;
    end else begin
      div_req.sum   = '0;
      div_req.recip = '0;
      div_req.full  = 1'b0;
    end
  end

  assign div_start = (state_r == S_RD2) && div_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: begin
        if (div_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r     <= in_ch.chan;
      sample_r   <= in_ch.sample;
      in_range_r <= (in_chan_x < CHAN_XW'(CHANNELS));
    end
    if (state_r == S_RD1) begin
      ring_addr_r <= ring_addr;
    end
  end

  mma_chan_state #(
    .CHANNELS (CHANNELS),
    .CW       (CW)
  ) u_chan_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx  (in_chan_x[CW-1:0]),
    .rd_data (cs_rd),
    .wr_en   (div_start && in_range_r),
    .wr_idx  (chan_idx_r),
    .wr_data (cs_new)
  );

  mma_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (RING_AW)
  ) u_ring_mem (
    .clk     (clk),
    .rd_en   (state_r == S_RD1),
    .rd_addr (ring_addr),
    .rd_data (ring_rd),
    .wr_en   (div_start && in_range_r),
    .wr_addr (ring_addr_r),
    .wr_data (sample_r)
  );

  mma_mean_div u_mean_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .req    (div_req),
    .ready  (div_ready),
    .out_ch (out_ch)
  );

  assign out_oor = (CHAN_XW'(out_ch.chan_out) >= CHAN_XW'(CHANNELS));

  `MMA_ASSERT_NEXT(a_accept_reads, in_acc, state_r == S_RD1, "accept did not start a read")
  `MMA_ASSERT_NEXT(a_rd1_to_rd2, state_r == S_RD1, state_r == S_RD2, "ring read skipped")
  `MMA_ASSERT_NOW(a_oor_zero, out_ch.valid && out_oor, (out_ch.mean == '0) && !out_ch.window_full, "nonzero result for absent channel")

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the multichannel moving average filter.
module tb;
  import mma_pkg::*;

  typedef struct {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] mean;
    logic                full;
  } mean_word_t;

  class mean_tracker;
    logic [SAMPLE_W-1:0] ring [DEF_CHANNELS][DEF_WINDOW];
    logic [SUM_W-1:0]    win_sum [DEF_CHANNELS];
    logic [POS_W-1:0]    wr_pos [DEF_CHANNELS];
    bit                  filled [DEF_CHANNELS];
    mean_word_t          due_means[$];
    int                  errors;
    int                  checked;

    function new();
      for (int c = 0; c < DEF_CHANNELS; c++) begin
        win_sum[c] = '0;
        wr_pos[c]  = '0;
        filled[c]  = 1'b0;
        for (int k = 0; k < DEF_WINDOW; k++) ring[c][k] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    // Predicts the result word for one accepted sample word.
    function void note_sample(logic [CHAN_W-1:0] c, logic [SAMPLE_W-1:0] s);
      mean_word_t       w;
      int unsigned      p;
      int unsigned      cnt;
      logic [SUM_W-1:0] acc;
      w.chan = c;
      w.mean = '0;
      w.full = 1'b0;
      if (c < DEF_CHANNELS) begin
        p   = wr_pos[c];
        acc = win_sum[c];
        // Only a full window evicts its oldest entry.
        if (filled[c]) acc = acc - ring[c][p];
        ring[c][p] = s;
        acc = acc + s;
        win_sum[c] = acc;
        p = (p + 1 == DEF_WINDOW) ? 0 : p + 1;
        wr_pos[c] = POS_W'(p);
        if (p == 0) filled[c] = 1'b1;
        cnt    = filled[c] ? DEF_WINDOW : p;
        w.mean = SAMPLE_W'(acc / cnt);
        w.full = filled[c];
      end
      due_means.push_back(w);
    endfunction

    function void check_result(logic [CHAN_W-1:0] c, logic [SAMPLE_W-1:0] m, logic f);
      mean_word_t w;
      checked++;
      if (due_means.size() == 0) begin
        $error("unexpected result word: chan_out %0d mean %0d window_full %0d", c, m, f);
        errors++;
      end else begin
        w = due_means.pop_front();
        if (c !== w.chan) begin
          $error("chan_out: expected %0d, actual %0d", w.chan, c);
          errors++;
        end
        if (m !== w.mean) begin
          $error("mean: expected %0d, actual %0d", w.mean, m);
          errors++;
        end
        if (f !== w.full) begin
          $error("window_full: expected %0d, actual %0d", w.full, f);
          errors++;
        end
      end
    endfunction

    function int pending();
      return due_means.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  mma_in_if  in_bus();
  mma_out_if out_bus();

  multichannel_moving_average uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  mean_tracker tracker;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_request;
  int hold_left;
  int words_sent;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver pacing; a requested hold-off keeps ready low until its count runs out.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready = 1'b0;
    end else begin
      out_bus.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready)
        tracker.check_result(out_bus.chan_out, out_bus.mean, out_bus.window_full);
      if (in_bus.valid && !in_bus.ready) stall_cycles++;
    end
  end

  task automatic send_word(input logic [CHAN_W-1:0] c, input logic [SAMPLE_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid  = 1'b1;
    in_bus.chan   = c;
    in_bus.sample = s;
    do @(posedge clk); while (!in_bus.ready);
    tracker.note_sample(c, s);
    words_sent++;
  endtask

  task automatic send_random(input int n);
    int                  r;
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(9);
      if (r < 2) s = '1;
      else if (r < 3) s = '0;
      else s = SAMPLE_W'($urandom_range(4095));
      send_word(CHAN_W'($urandom_range(DEF_CHANNELS - 1)), s);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    tracker       = new();
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    hold_request  = 0;
    hold_left     = 0;
    words_sent    = 0;
    stall_cycles  = 0;
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.chan   = '0;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: fill channel 0 at full scale, wrap it, evict with zeros, then channels 7 and 1 to 6.
    for (int i = 0; i < 12; i++) send_word(3'd0, 12'hFFF);
    send_word(3'd0, 12'h000);
    send_word(3'd0, 12'h000);
    send_word(3'd7, 12'hFFF);
    send_word(3'd7, 12'h000);
    send_word(3'd7, 12'h001);
    for (int c = 1; c < 7; c++) send_word(CHAN_W'(c), 12'h555 << (c % 2));
    drain();

    tx_idle_pct = 31;
    rx_idle_pct = 60;
    send_random(530);
    drain();

    tx_idle_pct = 60;
    rx_idle_pct = 31;
    send_random(530);
    drain();

    // No idling, but the receiver first holds off long enough to back up the input.
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 400;
    send_random(540);
    drain();

    if (tracker.pending() != 0) tracker.errors++;
    $display("Sent %0d sample words over %0d channels and checked %0d result words.",
             words_sent, DEF_CHANNELS, tracker.checked);
    $display("Three pacing phases ran; the input was held off for %0d cycles.", stall_cycles);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/mma_pkg.sv
hdl/mma_if.sv
hdl/mma_ring_mem.sv
hdl/mma_chan_state.sv
hdl/mma_mean_div.sv
hdl/multichannel_moving_average.sv
test/tb.sv
